// ----- rtl/multi_queue_with_join_defines.svh -----
// Assertion macros for the multi-queue manager.
// Included by RTL files that carry concurrent checks; define NO_ASSERTIONS to drop them.
`ifndef MULTI_QUEUE_WITH_JOIN_DEFINES_SVH
`define MULTI_QUEUE_WITH_JOIN_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that is disabled while reset is asserted.
`define MQJ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define MQJ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MQJ_ASSERT(label, clk, rst_n, prop, msg)
`define MQJ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/mqj_pkg.sv -----
// Types and constants of the multi-queue manager.
// Used by mqj_ram and multi_queue_with_join; depends on nothing.
`default_nettype none

package mqj_pkg;

  localparam int unsigned QUEUES  = 128;
  localparam int unsigned ENTRIES = 256;

  localparam int unsigned QW = $clog2(QUEUES);
  localparam int unsigned EW = $clog2(ENTRIES);
  // lengths, fresh count and links carry one more bit for the value ENTRIES
  localparam int unsigned LW = EW + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_LEAVE = 2'd1,
    OP_JOIN  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         queue_index;
    logic [6:0]         target_queue;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [8:0]         queue_length;
  } out_t;

  // one queue descriptor
  typedef struct packed {
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
    logic [LW-1:0] len;
  } qrec_t;

endpackage

`default_nettype wire

// ----- rtl/multi_queue_with_join.sv -----
// Each word is registered in stage 1, then in stage 2, then in the output register.
// Throughput: one word per cycle; input stalls only while a result waits and the
// output is stalled. Hazards between neighboring words are resolved by forwarding.
// Reset clears the queue occupancy flags, the free list and the fresh-entry count;
// the store and descriptor RAMs are not cleared and no clearing pass runs.
`default_nettype none
`include "multi_queue_with_join_defines.svh"

module multi_queue_with_join (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mqj_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mqj_pkg::out_t out_data_o
);

  logic adv;

  // stage 1: word plus descriptor reads
  logic                       s1_valid_q;
  mqj_pkg::in_t               s1_q;
  mqj_pkg::qrec_t             rq_raw, rt_raw;
  logic [mqj_pkg::QW-1:0]     q1, t1;
  mqj_pkg::qrec_t             rq1, rt1;
  logic                       ne_q1, ne_t1;
  logic [mqj_pkg::EW-1:0]     e1, rd_addr1;
  logic                       pop1, full1;

  // stage 2: effective descriptors plus entry reads
  logic                       s2_valid_q;
  mqj_pkg::in_t               s2_q;
  mqj_pkg::qrec_t             s2_rq, s2_rt;
  logic [mqj_pkg::EW-1:0]     s2_e;
  logic                       s2_pop, s2_full;
  logic [mqj_pkg::LW-1:0]     lrd;
  logic [31:0]                vrd;
  logic [mqj_pkg::QW-1:0]     q2, t2;

  // state updates produced by stage 2
  logic                       qwr_en, qwr_ne, clr_en;
  logic [mqj_pkg::QW-1:0]     qwr_addr, clr_addr;
  mqj_pkg::qrec_t             qwr_data;
  logic                       vwr_en, lwr_en;
  logic [mqj_pkg::EW-1:0]     vwr_addr, lwr_addr;
  logic [31:0]                vwr_data;
  logic [mqj_pkg::LW-1:0]     lwr_data;
  logic [mqj_pkg::LW-1:0]     join_len;
  mqj_pkg::out_t              out_d, out_q;
  logic                       out_valid_q;

  logic [mqj_pkg::QUEUES-1:0] ne_q;
  logic [mqj_pkg::LW-1:0]     free_head_q, free_head_d;
  logic [mqj_pkg::LW-1:0]     fresh_q, fresh_d;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Descriptor RAMs: two copies so source and target read in the same cycle.
  mqj_ram #(
    .WIDTH($bits(mqj_pkg::qrec_t)),
    .DEPTH(mqj_pkg::QUEUES)
  ) u_qmem_src (
    .clk_i   (clk_i),
    .we_i    (qwr_en && adv),
    .waddr_i (qwr_addr),
    .wdata_i (qwr_data),
    .re_i    (adv),
    .raddr_i (in_data_i.queue_index[mqj_pkg::QW-1:0]),
    .rdata_o (rq_raw)
  );

  mqj_ram #(
    .WIDTH($bits(mqj_pkg::qrec_t)),
    .DEPTH(mqj_pkg::QUEUES)
  ) u_qmem_tgt (
    .clk_i   (clk_i),
    .we_i    (qwr_en && adv),
    .waddr_i (qwr_addr),
    .wdata_i (qwr_data),
    .re_i    (adv),
    .raddr_i (in_data_i.target_queue[mqj_pkg::QW-1:0]),
    .rdata_o (rt_raw)
  );

  mqj_ram #(
    .WIDTH(32),
    .DEPTH(mqj_pkg::ENTRIES)
  ) u_vmem (
    .clk_i   (clk_i),
    .we_i    (vwr_en && adv),
    .waddr_i (vwr_addr),
    .wdata_i (vwr_data),
    .re_i    (adv),
    .raddr_i (rd_addr1),
    .rdata_o (vrd)
  );

  mqj_ram #(
    .WIDTH(mqj_pkg::LW),
    .DEPTH(mqj_pkg::ENTRIES)
  ) u_lmem (
    .clk_i   (clk_i),
    .we_i    (lwr_en && adv),
    .waddr_i (lwr_addr),
    .wdata_i (lwr_data),
    .re_i    (adv),
    .raddr_i (rd_addr1),
    .rdata_o (lrd)
  );

  // Stage 1: forward stage 2 updates, pick the entry to allocate.
  always_comb begin
    q1    = s1_q.queue_index[mqj_pkg::QW-1:0];
    t1    = s1_q.target_queue[mqj_pkg::QW-1:0];
    rq1   = rq_raw;
    rt1   = rt_raw;
    ne_q1 = ne_q[q1];
    ne_t1 = ne_q[t1];
    if (qwr_en && (qwr_addr == q1)) begin
      rq1   = qwr_data;
      ne_q1 = qwr_ne;
    end
    if (qwr_en && (qwr_addr == t1)) begin
      rt1   = qwr_data;
      ne_t1 = qwr_ne;
    end
    if (clr_en && (clr_addr == q1)) begin
      ne_q1 = 1'b0;
    end
    if (clr_en && (clr_addr == t1)) begin
      ne_t1 = 1'b0;
    end
    // an empty queue's descriptor may be stale; its length is forced to zero
    if (!ne_q1) begin
      rq1.len = '0;
    end
    if (!ne_t1) begin
      rt1.len = '0;
    end

    e1    = '0;
    pop1  = 1'b0;
    full1 = 1'b0;
    if (free_head_d != mqj_pkg::LW'(mqj_pkg::ENTRIES)) begin
      e1   = free_head_d[mqj_pkg::EW-1:0];
      pop1 = 1'b1;
    end else if (fresh_d != mqj_pkg::LW'(mqj_pkg::ENTRIES)) begin
      e1 = fresh_d[mqj_pkg::EW-1:0];
    end else begin
      full1 = 1'b1;
    end

    // leave reads the head entry, add reads the free entry's link
    rd_addr1 = (s1_q.operation == mqj_pkg::OP_LEAVE) ? rq1.head : e1;
  end

  // Stage 2: state updates and result.
  always_comb begin
    q2          = s2_q.queue_index[mqj_pkg::QW-1:0];
    t2          = s2_q.target_queue[mqj_pkg::QW-1:0];
    qwr_en      = 1'b0;
    qwr_ne      = 1'b0;
    qwr_addr    = q2;
    qwr_data    = s2_rq;
    clr_en      = 1'b0;
    clr_addr    = q2;
    vwr_en      = 1'b0;
    vwr_addr    = s2_e;
    vwr_data    = s2_q.item_value;
    lwr_en      = 1'b0;
    lwr_addr    = s2_rq.tail;
    lwr_data    = {1'b0, s2_e};
    join_len    = s2_rt.len + s2_rq.len;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    out_d.status        = mqj_pkg::ST_DONE;
    out_d.removed_value = '0;
    out_d.queue_length  = s2_rq.len;

    if (s2_valid_q) begin
      case (s2_q.operation)
        mqj_pkg::OP_ADD: begin
          if (s2_full) begin
            out_d.status = mqj_pkg::ST_FULL;
          end else begin
            vwr_en = 1'b1;
            if (s2_rq.len != '0) begin
              lwr_en = 1'b1;
            end
            qwr_en        = 1'b1;
            qwr_ne        = 1'b1;
            qwr_data.head = (s2_rq.len == '0) ? s2_e : s2_rq.head;
            qwr_data.tail = s2_e;
            qwr_data.len  = s2_rq.len + mqj_pkg::LW'(1);
            if (s2_pop) begin
              free_head_d = lrd;
            end else begin
              fresh_d = fresh_q + mqj_pkg::LW'(1);
            end
            out_d.queue_length = qwr_data.len;
          end
        end
        mqj_pkg::OP_LEAVE: begin
          if (s2_rq.len == '0) begin
            out_d.status = mqj_pkg::ST_EMPTY;
          end else begin
            out_d.removed_value = vrd;
            qwr_en        = 1'b1;
            qwr_data.head = lrd[mqj_pkg::EW-1:0];
            qwr_data.len  = s2_rq.len - mqj_pkg::LW'(1);
            qwr_ne        = (qwr_data.len != '0);
            // freed entry goes on top of the free list
            lwr_en      = 1'b1;
            lwr_addr    = s2_rq.head;
            lwr_data    = free_head_q;
            free_head_d = {1'b0, s2_rq.head};
            out_d.queue_length = qwr_data.len;
          end
        end
        mqj_pkg::OP_JOIN: begin
          out_d.queue_length = s2_rt.len;
          if ((q2 != t2) && (s2_rq.len != '0)) begin
            qwr_en   = 1'b1;
            qwr_ne   = 1'b1;
            qwr_addr = t2;
            qwr_data = s2_rt;
            if (s2_rt.len == '0) begin
              qwr_data.head = s2_rq.head;
            end else begin
              lwr_en   = 1'b1;
              lwr_addr = s2_rt.tail;
              lwr_data = {1'b0, s2_rq.head};
            end
            qwr_data.tail = s2_rq.tail;
            qwr_data.len  = join_len;
            clr_en        = 1'b1;
            out_d.queue_length = join_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ne_q        <= '0;
      free_head_q <= mqj_pkg::LW'(mqj_pkg::ENTRIES);
      fresh_q     <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      if (qwr_en) begin
        ne_q[qwr_addr] <= qwr_ne;
      end
      if (clr_en) begin
        ne_q[clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= in_data_i;
      s2_q    <= s1_q;
      s2_rq   <= rq1;
      s2_rt   <= rt1;
      s2_e    <= e1;
      s2_pop  <= pop1;
      s2_full <= full1;
      out_q   <= out_d;
    end
  end

  `MQJ_ASSERT_ALWAYS(a_fresh_bound, clk_i, fresh_q <= mqj_pkg::LW'(mqj_pkg::ENTRIES), "fresh count beyond store size")
  `MQJ_ASSERT(a_full_means_no_entry, clk_i, rst_ni, s2_valid_q && (s2_q.operation == mqj_pkg::OP_ADD) && s2_full |-> (free_head_q == mqj_pkg::LW'(mqj_pkg::ENTRIES)) && (fresh_q == mqj_pkg::LW'(mqj_pkg::ENTRIES)), "full reported with a free entry left")
  `MQJ_ASSERT(a_leave_nonempty, clk_i, rst_ni, s2_valid_q && (s2_q.operation == mqj_pkg::OP_LEAVE) && (s2_rq.len != '0) |-> ne_q[q2], "leave from a queue marked empty")
  `MQJ_ASSERT(a_join_len_bound, clk_i, rst_ni, clr_en |-> join_len <= mqj_pkg::LW'(mqj_pkg::ENTRIES), "joined length exceeds store size")

endmodule

`default_nettype wire

// ----- rtl/mqj_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
// A read of the address written in the same cycle returns the new word.
// Depends on mqj_pkg for default sizes.
`default_nettype none

module mqj_ram #(
  parameter int unsigned WIDTH = mqj_pkg::LW,
  parameter int unsigned DEPTH = mqj_pkg::ENTRIES,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
